// ===== design/imm_pkg.sv =====
// Shared constants, types and helper functions of the integer matrix multiplier.
package imm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DATA_WIDTH = 32;

   localparam int WORD_W    = 32;
   localparam int POS_W     = 3;
   localparam int CMD_W     = 2;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B     = 2'd2;

   localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] inner;
      logic [DIM_W-1:0] cols;
   } dims_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             last_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [WORD_W-1:0] value;
   } result_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [WORD_W-1:0] v);
      return DATA_WIDTH'(v);
   endfunction

   function automatic logic [WORD_W-1:0] to_word(input logic signed [DATA_WIDTH-1:0] v);
      return WORD_W'(v);
   endfunction

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
   endfunction

endpackage

// ===== design/imm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module imm_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/imm_seq.sv =====
// Compute sequencer: walks row, column and inner index and issues RAM reads.
module imm_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic                    done,
   input  imm_pkg::dims_type       dims,
   output logic                    busy,
   output logic [imm_pkg::ADDR_W-1:0] addr_a,
   output logic [imm_pkg::ADDR_W-1:0] addr_b,
   output imm_pkg::tag_type        tag
);
   import imm_pkg::*;

   logic             active_ff, active_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             last_i, last_j, last_k;

   assign last_i = (DIM_W'(i_ff) + DIM_W'(1)) == dims.rows;
   assign last_j = (DIM_W'(j_ff) + DIM_W'(1)) == dims.cols;
   assign last_k = (DIM_W'(k_ff) + DIM_W'(1)) == dims.inner;

   always_comb begin
      active_in = active_ff;
      busy_in   = busy_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      if (done) begin
         busy_in = 1'b0;
      end
      if (go) begin
         active_in = 1'b1;
         busy_in   = 1'b1;
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
      end else if (active_ff) begin
         if (!last_k) begin
            k_in = k_ff + IDX_W'(1);
         end else begin
            k_in = '0;
            if (!last_j) begin
               j_in = j_ff + IDX_W'(1);
            end else begin
               j_in = '0;
               if (!last_i) begin
                  i_in = i_ff + IDX_W'(1);
               end else begin
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         busy_ff   <= 1'b0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
      end else begin
         active_ff <= active_in;
         busy_ff   <= busy_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
      end
   end

   assign addr_a = elem_addr(i_ff, k_ff);
   assign addr_b = elem_addr(k_ff, j_ff);

   assign tag.valid     = active_ff;
   assign tag.first     = (k_ff == '0);
   assign tag.last_k    = last_k;
   assign tag.last_elem = last_i && last_j;
   assign tag.row       = i_ff;
   assign tag.col       = j_ff;
   assign busy          = busy_ff;

endmodule

// ===== design/imm_mac.sv =====
// Pipelined multiply-accumulate: product register, accumulator and result register.
module imm_mac (
   input  logic                           clock,
   input  logic                           reset,
   input  imm_pkg::tag_type               tag,
   input  logic [imm_pkg::DATA_WIDTH-1:0] a_data,
   input  logic [imm_pkg::DATA_WIDTH-1:0] b_data,
   output imm_pkg::result_type            result
);
   import imm_pkg::*;

   tag_type           tag1_ff, tag2_ff;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   result_type        res_ff, res_in;

   // tag1 lines up with RAM read data, tag2 with the product
   assign prod_in = to_word(a_data) * to_word(b_data);
   assign acc_in  = tag2_ff.first ? prod_ff : acc_ff + prod_ff;

   always_comb begin
      res_in       = res_ff;
      res_in.valid = tag2_ff.valid && tag2_ff.last_k;
      if (tag2_ff.valid && tag2_ff.last_k) begin
         res_in.last  = tag2_ff.last_elem;
         res_in.row   = tag2_ff.row;
         res_in.col   = tag2_ff.col;
         res_in.value = acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         res_ff.valid  <= 1'b0;
      end else begin
         tag1_ff.valid <= tag.valid;
         tag2_ff.valid <= tag1_ff.valid;
         res_ff.valid  <= res_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff.first     <= tag.first;
      tag1_ff.last_k    <= tag.last_k;
      tag1_ff.last_elem <= tag.last_elem;
      tag1_ff.row       <= tag.row;
      tag1_ff.col       <= tag.col;
      tag2_ff.first     <= tag1_ff.first;
      tag2_ff.last_k    <= tag1_ff.last_k;
      tag2_ff.last_elem <= tag1_ff.last_elem;
      tag2_ff.row       <= tag1_ff.row;
      tag2_ff.col       <= tag1_ff.col;
      prod_ff           <= prod_in;
      res_ff.last       <= res_in.last;
      res_ff.row        <= res_in.row;
      res_ff.col        <= res_in.col;
      res_ff.value      <= res_in.value;
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== design/integer_matrix_multiply.sv =====
// Integer matrix multiplier top level: command port, CSRs, element RAMs and datapath.
//
// Usage:
//   Command words are taken at a clock edge where start is high and busy is low.
//   Write A / write B store one element at (row, col); busy stays low.
//   Writes may go to any of the 8 x 8 store positions, whatever the current sizes.
//   Compute raises busy and emits rows_a * cols_b result words in row-major order,
//   each shown for one cycle with rsp_valid high; rsp_last marks the final word.
//   Each result word is built by one shared multiply-accumulate fed by the two RAM
//   read ports. busy drops in the cycle after the last word is shown.
//   The result port has no backpressure; words must be taken as they appear.
//   CSR writes (csr_index 0 rows_a, 1 inner_size, 2 cols_b) are always ready and
//   belong only in idle periods. A size of 0 acts as 1, above 8 acts as 8.
//   Reset (synchronous, active high) sets all sizes to 8 and idles the block;
//   matrix contents are not cleared and must be written before use.
module integer_matrix_multiply (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [imm_pkg::CMD_W-1:0]         req_cmd,
   input  logic [imm_pkg::POS_W-1:0]         req_row_index,
   input  logic [imm_pkg::POS_W-1:0]         req_col_index,
   input  logic signed [imm_pkg::WORD_W-1:0] req_element_value,
   output logic                              rsp_valid,
   output logic [imm_pkg::POS_W-1:0]         rsp_out_row,
   output logic [imm_pkg::POS_W-1:0]         rsp_out_col,
   output logic signed [imm_pkg::WORD_W-1:0] rsp_product_value,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [imm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imm_pkg::CFG_W-1:0]         csr_data
);
   import imm_pkg::*;

   logic [CFG_W-1:0]      rows_a_ff, inner_size_ff, cols_b_ff;
   dims_type              dims;
   logic                  accept, in_range, wr_a, wr_b, go;
   logic [ADDR_W-1:0]     wr_addr, addr_a, addr_b;
   logic [DATA_WIDTH-1:0] wr_data, a_data, b_data;
   tag_type               tag;
   result_type            result;
   logic                  done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff     <= DIM_RESET;
         inner_size_ff <= DIM_RESET;
         cols_b_ff     <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROWS_A:     rows_a_ff     <= csr_data;
            REG_INNER_SIZE: inner_size_ff <= csr_data;
            REG_COLS_B:     cols_b_ff     <= csr_data;
            default:        ;
         endcase
      end
   end

   assign dims.rows  = clamp_dim(rows_a_ff);
   assign dims.inner = clamp_dim(inner_size_ff);
   assign dims.cols  = clamp_dim(cols_b_ff);

   assign accept   = start && !busy;
   assign in_range = (int'(req_row_index) < MAX_DIM) && (int'(req_col_index) < MAX_DIM);
   assign wr_a     = accept && in_range && (req_cmd == CMD_WRITE_A);
   assign wr_b     = accept && in_range && (req_cmd == CMD_WRITE_B);
   assign go       = accept && (req_cmd == CMD_COMPUTE);
   assign wr_addr  = elem_addr(IDX_W'(req_row_index), IDX_W'(req_col_index));
   assign wr_data  = to_store(req_element_value);
   assign done     = result.valid && result.last;

   imm_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH), .ADDR_W(ADDR_W)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_a),
      .rd_data (a_data)
   );

   imm_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH), .ADDR_W(ADDR_W)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_b),
      .rd_data (b_data)
   );

   imm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .done   (done),
      .dims   (dims),
      .busy   (busy),
      .addr_a (addr_a),
      .addr_b (addr_b),
      .tag    (tag)
   );

   imm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .tag    (tag),
      .a_data (a_data),
      .b_data (b_data),
      .result (result)
   );

   assign rsp_valid         = result.valid;
   assign rsp_last          = result.last;
   assign rsp_out_row       = POS_W'(result.row);
   assign rsp_out_col       = POS_W'(result.col);
   assign rsp_product_value = result.value;

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("result word outside a compute run");

   a_nothing_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result word after the last one");

   a_compute_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_COMPUTE) |=> busy)
      else $error("compute accepted without busy");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid)
      else $error("result word while idle");

endmodule

// ===== test/integer_matrix_multiply_tb.sv =====
// Self-checking testbench for the integer matrix multiplier: random command words vs. a predictor.
`timescale 1ns / 1ps

module integer_matrix_multiply_tb;
   import imm_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [WORD_W-1:0] value;
   } cmd_word_type;

   typedef struct packed {
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [WORD_W-1:0] value;
      logic              last;
   } result_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [POS_W-1:0]      req_row_index = '0;
   logic [POS_W-1:0]      req_col_index = '0;
   logic signed [WORD_W-1:0] req_element_value = '0;
   logic                  rsp_valid;
   logic [POS_W-1:0]      rsp_out_row;
   logic [POS_W-1:0]      rsp_out_col;
   logic signed [WORD_W-1:0] rsp_product_value;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_data = '0;

   integer_matrix_multiply u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // predictor state
   logic [WORD_W-1:0] matrix_a [DEPTH];
   logic [WORD_W-1:0] matrix_b [DEPTH];
   logic [CFG_W-1:0]  dims_cfg [0:2];

   // stimulus bookkeeping
   bit                a_loaded [DEPTH];
   bit                b_loaded [DEPTH];
   cmd_word_type      pending_cmd_words [$];
   result_word_type   expected_products [$];
   cmd_word_type      driven_word;
   result_word_type   want;
   int                pending_words = 0;
   int                words_made = 0;
   int                gap_left = 0;
   bit                gaps_enabled = 1'b1;
   int                mismatch_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int eff_dim(input logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
   endfunction

   function automatic void apply_command(input cmd_word_type w);
      int m;
      int n;
      int p;
      logic [WORD_W-1:0] acc;
      result_word_type r;
      case (w.cmd)
         CMD_WRITE_A: matrix_a[w.row * MAX_DIM + w.col] = w.value;
         CMD_WRITE_B: matrix_b[w.row * MAX_DIM + w.col] = w.value;
         CMD_COMPUTE: begin
            m = eff_dim(dims_cfg[REG_ROWS_A]);
            n = eff_dim(dims_cfg[REG_INNER_SIZE]);
            p = eff_dim(dims_cfg[REG_COLS_B]);
            for (int i = 0; i < m; i++) begin
               for (int j = 0; j < p; j++) begin
                  acc = '0;
                  for (int k = 0; k < n; k++) begin
                     acc += matrix_a[i * MAX_DIM + k] * matrix_b[k * MAX_DIM + j];
                  end
                  r.row   = POS_W'(i);
                  r.col   = POS_W'(j);
                  r.value = acc;
                  r.last  = (i == m - 1) && (j == p - 1);
                  expected_products.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] exp_val);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("%0t ERROR %s: got %0h, wanted %0h", $time, what, got, exp_val);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (!(start && busy)) begin
         if (start) begin
            apply_command(driven_word);
            pending_words--;
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmd_words.size() > 0) begin
            driven_word = pending_cmd_words.pop_front();
            req_cmd           <= driven_word.cmd;
            req_row_index     <= driven_word.row;
            req_col_index     <= driven_word.col;
            req_element_value <= driven_word.value;
            start             <= 1'b1;
            if (gaps_enabled && $urandom_range(0, 4) == 0)
               gap_left = $urandom_range(1, 13);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_products.size() == 0) begin
            report_mismatch("result word with none pending", rsp_product_value, '0);
         end else begin
            want = expected_products.pop_front();
            if (rsp_out_row !== want.row)
               report_mismatch("out_row", WORD_W'(rsp_out_row), WORD_W'(want.row));
            if (rsp_out_col !== want.col)
               report_mismatch("out_col", WORD_W'(rsp_out_col), WORD_W'(want.col));
            if (rsp_product_value !== want.value)
               report_mismatch("product_value", rsp_product_value, want.value);
            if (rsp_last !== want.last)
               report_mismatch("last", WORD_W'(rsp_last), WORD_W'(want.last));
         end
      end
   end

   task automatic queue_word(input logic [CMD_W-1:0] cmd, input int r, input int c,
                             input logic [WORD_W-1:0] v);
      cmd_word_type w;
      w.cmd   = cmd;
      w.row   = POS_W'(r);
      w.col   = POS_W'(c);
      w.value = v;
      if (cmd == CMD_WRITE_A) a_loaded[w.row * MAX_DIM + w.col] = 1'b1;
      if (cmd == CMD_WRITE_B) b_loaded[w.row * MAX_DIM + w.col] = 1'b1;
      if (cmd != CMD_UNUSED) words_made++;
      pending_words++;
      pending_cmd_words.push_back(w);
   endtask

   task automatic wait_idle();
      while (pending_words != 0 || expected_products.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dims_cfg[idx] = val;
   endtask

   task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                           input logic [CFG_W-1:0] cols);
      write_csr(REG_ROWS_A, rows);
      write_csr(REG_INNER_SIZE, inner);
      write_csr(REG_COLS_B, cols);
   endtask

   function automatic logic [WORD_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return WORD_W'($urandom_range(0, 16) - 8);
         default: return $urandom();
      endcase
   endfunction

   // load every operand the next compute reads that was never written
   task automatic fill_operands();
      int m;
      int n;
      int p;
      m = eff_dim(dims_cfg[REG_ROWS_A]);
      n = eff_dim(dims_cfg[REG_INNER_SIZE]);
      p = eff_dim(dims_cfg[REG_COLS_B]);
      for (int i = 0; i < m; i++)
         for (int k = 0; k < n; k++)
            if (!a_loaded[i * MAX_DIM + k]) queue_word(CMD_WRITE_A, i, k, rand_value());
      for (int k = 0; k < n; k++)
         for (int j = 0; j < p; j++)
            if (!b_loaded[k * MAX_DIM + j]) queue_word(CMD_WRITE_B, k, j, rand_value());
   endtask

   task automatic random_words(input int quota);
      int made0;
      int m;
      int n;
      int p;
      made0 = words_made;
      m = eff_dim(dims_cfg[REG_ROWS_A]);
      n = eff_dim(dims_cfg[REG_INNER_SIZE]);
      p = eff_dim(dims_cfg[REG_COLS_B]);
      while (words_made - made0 < quota) begin
         case ($urandom_range(0, 9))
            0: queue_word(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
            1: queue_word($urandom_range(0, 1) ? CMD_WRITE_A : CMD_WRITE_B,
                          $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(0, 1))
                     queue_word(CMD_WRITE_A, $urandom_range(0, m - 1), $urandom_range(0, n - 1),
                                rand_value());
                  else
                     queue_word(CMD_WRITE_B, $urandom_range(0, n - 1), $urandom_range(0, p - 1),
                                rand_value());
               end
               fill_operands();
               queue_word(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int plan_rows [7];
      int plan_inner [7];
      int plan_cols [7];
      plan_rows  = '{0, 15, 1, 1, 8, 3, 15};
      plan_inner = '{0, 1, 15, 1, 1, 5, 15};
      plan_cols  = '{0, 1, 1, 15, 8, 2, 15};
      foreach (dims_cfg[i]) dims_cfg[i] = DIM_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme values and indexes, unused command, overwrite
      set_dims(4'd2, 4'd2, 4'd2);
      queue_word(CMD_WRITE_A, 0, 0, 32'h8000_0000);
      queue_word(CMD_WRITE_A, 0, 1, 32'h7FFF_FFFF);
      queue_word(CMD_WRITE_A, 1, 0, 32'hFFFF_FFFF);
      queue_word(CMD_WRITE_A, 1, 1, 32'h0000_0000);
      queue_word(CMD_WRITE_B, 0, 0, 32'h8000_0000);
      queue_word(CMD_WRITE_B, 0, 1, 32'h0000_0001);
      queue_word(CMD_WRITE_B, 1, 0, 32'h7FFF_FFFF);
      queue_word(CMD_WRITE_B, 1, 1, 32'hFFFF_FFFF);
      queue_word(CMD_WRITE_A, 7, 7, 32'h7FFF_FFFF);
      queue_word(CMD_WRITE_B, 7, 7, 32'h8000_0000);
      queue_word(CMD_UNUSED, 7, 7, 32'hFFFF_FFFF);
      queue_word(CMD_COMPUTE, 0, 0, 32'h0000_0000);
      queue_word(CMD_WRITE_A, 0, 0, 32'h0000_0001);
      queue_word(CMD_COMPUTE, 7, 7, 32'hFFFF_FFFF);
      wait_idle();

      // extreme and mixed sizes; sender drains fully between settings
      for (int ph = 0; ph < 7; ph++) begin
         gaps_enabled = (ph % 3 != 2);
         set_dims(CFG_W'(plan_rows[ph]), CFG_W'(plan_inner[ph]), CFG_W'(plan_cols[ph]));
         random_words(6);
         wait_idle();
      end
      for (int ph = 0; ph < 4; ph++) begin
         gaps_enabled = (ph < 3);
         set_dims(CFG_W'($urandom_range(0, 9)), CFG_W'($urandom_range(0, 9)),
                  CFG_W'($urandom_range(0, 9)));
         random_words(6);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
